// ===== rtl/ptb_pkg.sv =====
// Shared package for the periodic timer bank: channel count, operation codes,
// field widths and the command and status structs between top and channels.
// No dependencies.
package ptb_pkg;

	// Bank size and derived widths
	localparam int CHANNELS = 3;
	localparam int CIDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Field widths
	localparam int OP_W     = 4;
	localparam int CH_W     = 2;
	localparam int TICK_W   = 16;
	localparam int TMO_W    = 32;
	localparam int MASK_W   = 3;

	// Operation codes
	localparam logic [OP_W-1:0] OP_TICK        = 4'd0;
	localparam logic [OP_W-1:0] OP_ALLOC       = 4'd1;
	localparam logic [OP_W-1:0] OP_FREE        = 4'd2;
	localparam logic [OP_W-1:0] OP_START       = 4'd3;
	localparam logic [OP_W-1:0] OP_STOP        = 4'd4;
	localparam logic [OP_W-1:0] OP_TOGGLE      = 4'd5;
	localparam logic [OP_W-1:0] OP_RESTART     = 4'd6;
	localparam logic [OP_W-1:0] OP_RESET       = 4'd7;
	localparam logic [OP_W-1:0] OP_SET_TIMEOUT = 4'd8;
	localparam logic [OP_W-1:0] OP_QUERY       = 4'd9;

	// Per-channel command, at most one bit set, zero when nothing advances
	typedef struct packed {
		logic tick;
		logic alloc;
		logic free;
		logic start;
		logic stop;
		logic toggle;
		logic restart;
		logic clear;
		logic set_tmo;
	} chan_cmd_t;

	// Per-channel status: current allocation plus state after the command, and the expiry flag
	typedef struct packed {
		logic             alloc;
		logic             alloc_nxt;
		logic             run_nxt;
		logic [TMO_W-1:0] period_nxt;
		logic             expired;
	} chan_stat_t;

endpackage

// ===== rtl/ptb_chan.sv =====
// One timer channel of the periodic timer bank: allocation, run state,
// saturating elapsed counter and period. Depends on ptb_pkg.
module ptb_chan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ptb_pkg::chan_cmd_t         cmd,
	input  logic [ptb_pkg::TICK_W-1:0] tick_count,
	input  logic [ptb_pkg::TMO_W-1:0]  timeout_value,
	output ptb_pkg::chan_stat_t        stat
);

	logic                      alloc_q;
	logic                      run_q;
	logic [ptb_pkg::TMO_W-1:0] elapsed_q;
	logic [ptb_pkg::TMO_W-1:0] period_q;

	logic                      alloc_d;
	logic                      run_d;
	logic [ptb_pkg::TMO_W-1:0] elapsed_d;
	logic [ptb_pkg::TMO_W-1:0] period_d;
	logic [ptb_pkg::TMO_W:0]   sum;
	logic [ptb_pkg::TMO_W-1:0] sum_sat;
	logic                      expired;

	// Tick arithmetic: add with saturation, then compare against period
	always_comb begin
		sum     = {1'b0, elapsed_q} + (ptb_pkg::TMO_W + 1)'(tick_count);
		sum_sat = sum[ptb_pkg::TMO_W] ? '1 : sum[ptb_pkg::TMO_W-1:0];
		expired = cmd.tick && alloc_q && run_q && (sum_sat >= period_q);
	end

	// Next state; the top qualifies commands so only one is set
	always_comb begin
		alloc_d   = alloc_q;
		run_d     = run_q;
		elapsed_d = elapsed_q;
		period_d  = period_q;
		if (cmd.tick && alloc_q && run_q) begin
			elapsed_d = expired ? '0 : sum_sat;
		end
		if (cmd.alloc) begin
			alloc_d   = 1'b1;
			run_d     = 1'b0;
			elapsed_d = '0;
			period_d  = timeout_value;
		end
		if (cmd.free) begin
			alloc_d   = 1'b0;
			run_d     = 1'b0;
			elapsed_d = '0;
		end
		if (cmd.start) begin
			run_d = 1'b1;
		end
		if (cmd.stop) begin
			run_d = 1'b0;
		end
		if (cmd.toggle) begin
			run_d = !run_q;
		end
		if (cmd.restart) begin
			elapsed_d = '0;
			run_d     = 1'b1;
		end
		if (cmd.clear) begin
			elapsed_d = '0;
			run_d     = 1'b0;
		end
		if (cmd.set_tmo) begin
			period_d  = timeout_value;
			elapsed_d = '0;
		end
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alloc_q   <= 1'b0;
			run_q     <= 1'b0;
			elapsed_q <= '0;
			period_q  <= '0;
		end else begin
			alloc_q   <= alloc_d;
			run_q     <= run_d;
			elapsed_q <= elapsed_d;
			period_q  <= period_d;
		end
	end

	// Status to the top
	always_comb begin
		stat.alloc      = alloc_q;
		stat.alloc_nxt  = alloc_d;
		stat.run_nxt    = run_d;
		stat.period_nxt = period_d;
		stat.expired    = expired;
	end

endmodule

// ===== rtl/periodic_timer_bank_core.sv =====
// Top level of the periodic timer bank: input register, operation decode,
// lowest-free allocation, channel array and result register.
// Depends on ptb_pkg and ptb_chan.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per beat:
//   operation, channel, tick_count, timeout_value. Output channel
//   (out_valid / out_stall) returns exactly one result beat per input beat:
//   expired_mask, granted_channel, rejected, channel_enabled,
//   channel_timeout.
//   Flow: an accepted beat is held in the input register, executed against the
//   channel state once the result slot is free or being drained, and its
//   result is written to the result register that drives the outputs.
//   Throughput: one operation per cycle while out_stall holds no result. All channels update in parallel in
//   the execute cycle with one saturating add and one compare each, and the
//   state written at that edge is what the next operation sees.
//   Reset: arst_n clears every channel (not allocated, stopped, count and
//   period zero) and empties both registers.
//   Stall: while out_stall holds a result, the registered operation waits
//   and in_stall rises; once that slot is full nothing more is accepted.
module periodic_timer_bank_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [ptb_pkg::OP_W-1:0]     operation,
	input  logic [ptb_pkg::CH_W-1:0]     channel,
	input  logic [ptb_pkg::TICK_W-1:0]   tick_count,
	input  logic [ptb_pkg::TMO_W-1:0]    timeout_value,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [ptb_pkg::MASK_W-1:0]   expired_mask,
	output logic [ptb_pkg::CH_W-1:0]     granted_channel,
	output logic                         rejected,
	output logic                         channel_enabled,
	output logic [ptb_pkg::TMO_W-1:0]    channel_timeout
);

	localparam int PAD_W = ptb_pkg::CHANNELS + ptb_pkg::MASK_W;

	// Input register
	logic                       valid_s1;
	logic [ptb_pkg::OP_W-1:0]   op_s1;
	logic [ptb_pkg::CH_W-1:0]   ch_s1;
	logic [ptb_pkg::TICK_W-1:0] tick_s1;
	logic [ptb_pkg::TMO_W-1:0]  tmo_s1;

	// Result register
	logic                       out_valid_q;
	logic [ptb_pkg::MASK_W-1:0] mask_q;
	logic [ptb_pkg::CH_W-1:0]   granted_q;
	logic                       rej_q;
	logic                       en_q;
	logic [ptb_pkg::TMO_W-1:0]  per_q;

	logic                       advance;
	logic                       in_take;

	ptb_pkg::chan_cmd_t         cmd   [ptb_pkg::CHANNELS];
	ptb_pkg::chan_stat_t        stat  [ptb_pkg::CHANNELS];

	logic [ptb_pkg::CHANNELS-1:0] sel_vec;
	logic [ptb_pkg::CHANNELS-1:0] live_vec;
	logic [ptb_pkg::CHANNELS-1:0] free_vec;
	logic [ptb_pkg::CHANNELS-1:0] grant_vec;
	logic [ptb_pkg::CHANNELS-1:0] report_vec;
	logic [ptb_pkg::CHANNELS-1:0] expired_vec;
	logic [PAD_W-1:0]             expired_pad;
	logic [ptb_pkg::CIDX_W-1:0]   grant_idx;
	logic                         tmo_nz;
	logic                         alloc_ok;
	logic                         live_any;
	logic                         is_addr_op;

	logic [ptb_pkg::MASK_W-1:0]   mask_d;
	logic [ptb_pkg::CH_W-1:0]     granted_d;
	logic                         rej_d;
	logic                         en_d;
	logic [ptb_pkg::TMO_W-1:0]    per_d;

	// Handshake: execute when the result slot is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1   <= operation;
			ch_s1   <= channel;
			tick_s1 <= tick_count;
			tmo_s1  <= timeout_value;
		end
	end

	// Channel select, liveness and lowest free channel
	always_comb begin
		for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
			sel_vec[i]     = (32'(ch_s1) == i);
			live_vec[i]    = sel_vec[i] && stat[i].alloc;
			free_vec[i]    = !stat[i].alloc;
			expired_vec[i] = stat[i].expired;
		end
		grant_vec = free_vec & (~free_vec + ptb_pkg::CHANNELS'(1));
		grant_idx = '0;
		for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
			if (grant_vec[i]) begin
				grant_idx = grant_idx | ptb_pkg::CIDX_W'(i);
			end
		end
		tmo_nz   = (tmo_s1 != '0);
		alloc_ok = tmo_nz && (|free_vec);
		live_any = |live_vec;
	end

	// Operation decode into per-channel commands
	always_comb begin
		is_addr_op = 1'b0;
		for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
			cmd[i] = '0;
		end
		unique case (op_s1)
			ptb_pkg::OP_TICK: begin
				for (int i = 0; i < ptb_pkg::CHANNELS; i++) cmd[i].tick = advance;
			end
			ptb_pkg::OP_ALLOC: begin
				for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
					cmd[i].alloc = advance && alloc_ok && grant_vec[i];
				end
			end
			ptb_pkg::OP_FREE: begin
				is_addr_op = 1'b1;
				for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
					cmd[i].free = advance && live_vec[i];
				end
			end
			ptb_pkg::OP_START: begin
				is_addr_op = 1'b1;
				for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
					cmd[i].start = advance && live_vec[i];
				end
			end
			ptb_pkg::OP_STOP: begin
				is_addr_op = 1'b1;
				for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
					cmd[i].stop = advance && live_vec[i];
				end
			end
			ptb_pkg::OP_TOGGLE: begin
				is_addr_op = 1'b1;
				for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
					cmd[i].toggle = advance && live_vec[i];
				end
			end
			ptb_pkg::OP_RESTART: begin
				is_addr_op = 1'b1;
				for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
					cmd[i].restart = advance && live_vec[i];
				end
			end
			ptb_pkg::OP_RESET: begin
				is_addr_op = 1'b1;
				for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
					cmd[i].clear = advance && live_vec[i];
				end
			end
			ptb_pkg::OP_SET_TIMEOUT: begin
				is_addr_op = 1'b1;
				for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
					cmd[i].set_tmo = advance && live_vec[i] && tmo_nz;
				end
			end
			ptb_pkg::OP_QUERY: begin
				is_addr_op = 1'b1;
			end
			default: begin
				is_addr_op = 1'b0;
			end
		endcase
	end

	// Channel array
	for (genvar g = 0; g < ptb_pkg::CHANNELS; g++) begin : g_chan
		ptb_chan u_chan (
			.clk           (clk),
			.arst_n        (arst_n),
			.cmd           (cmd[g]),
			.tick_count    (tick_s1),
			.timeout_value (tmo_s1),
			.stat          (stat[g])
		);
	end

	// Result fields
	always_comb begin
		expired_pad = PAD_W'(expired_vec);
		mask_d      = (op_s1 == ptb_pkg::OP_TICK) ? expired_pad[ptb_pkg::MASK_W-1:0] : '0;
		granted_d   = '0;
		rej_d       = 1'b0;
		report_vec  = '0;
		if (op_s1 == ptb_pkg::OP_ALLOC) begin
			rej_d = !alloc_ok;
			if (alloc_ok) begin
				granted_d  = ptb_pkg::CH_W'(grant_idx);
				report_vec = grant_vec;
			end
		end else if (is_addr_op) begin
			report_vec = live_vec;
			if (op_s1 == ptb_pkg::OP_SET_TIMEOUT) begin
				rej_d = !live_any || !tmo_nz;
			end
		end
		en_d  = 1'b0;
		per_d = '0;
		for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
			if (report_vec[i] && stat[i].alloc_nxt) begin
				en_d  = en_d | stat[i].run_nxt;
				per_d = per_d | stat[i].period_nxt;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mask_q    <= mask_d;
			granted_q <= granted_d;
			rej_q     <= rej_d;
			en_q      <= en_d;
			per_q     <= per_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign expired_mask    = mask_q;
	assign granted_channel = granted_q;
	assign rejected        = rej_q;
	assign channel_enabled = en_q;
	assign channel_timeout = per_q;

	// Checks
	a_grant_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(grant_vec))
		else $error("grant vector not one-hot");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("executed operation produced no result");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked result");

	a_mask_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(rej_q && (mask_q != '0)))
		else $error("result both rejected and expired");

endmodule

// ===== test/testbench.sv =====
// Testbench for periodic_timer_bank_core: directed and random timer operations,
// each result checked against a behavioral model of the channel bank.
// Depends on ptb_pkg and the periodic_timer_bank_core RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int              CLK_PERIOD   = 8;
	localparam int              RESET_CYCLES = 7;
	localparam int              RANDOM_OPS   = 1600;
	localparam int              CALM_OPS     = 150;
	localparam int              DRAIN_CYCLES = 8;
	localparam int              MAX_PRINTS   = 200;
	localparam longint          WATCHDOG_NS  = 64'd5_000_000;
	localparam logic [ptb_pkg::OP_W-1:0] OP_UNDEF_LO =
		ptb_pkg::OP_W'(ptb_pkg::OP_QUERY + 1);
	localparam logic [ptb_pkg::OP_W-1:0] OP_UNDEF_HI = '1;

	// One result beat, fields in port order
	typedef struct packed {
		logic [ptb_pkg::MASK_W-1:0] expired;
		logic [ptb_pkg::CH_W-1:0]   granted;
		logic                       rejected;
		logic                       enabled;
		logic [ptb_pkg::TMO_W-1:0]  timeout;
	} timer_status_t;

	// Channel bank model plus the queue of status beats still owed by the block
	class timer_bank_checker;
		bit                       in_use  [ptb_pkg::CHANNELS];
		bit                       running [ptb_pkg::CHANNELS];
		bit [ptb_pkg::TMO_W-1:0]  elapsed [ptb_pkg::CHANNELS];
		bit [ptb_pkg::TMO_W-1:0]  period  [ptb_pkg::CHANNELS];
		timer_status_t            owed_status[$];
		int unsigned              mismatches;
		int unsigned              beats_seen;

		function int pending();
			return owed_status.size();
		endfunction

		task report(string what);
			mismatches++;
			if (mismatches <= MAX_PRINTS)
				$display("[%0t] result %0d: %s", $time, beats_seen, what);
		endtask

		// Apply one accepted operation to the bank and queue the status it owes
		function void note_operation(logic [ptb_pkg::OP_W-1:0] op,
				logic [ptb_pkg::CH_W-1:0] ch, logic [ptb_pkg::TICK_W-1:0] ticks,
				logic [ptb_pkg::TMO_W-1:0] tmo);
			timer_status_t             st;
			logic [ptb_pkg::TMO_W:0]   sum;
			bit                        live;
			st   = '0;
			live = 1'b0;
			if (ch < ptb_pkg::CHANNELS)
				live = in_use[ch];

			if (op == ptb_pkg::OP_TICK) begin
				for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
					if (in_use[i] && running[i]) begin
						// saturating add, then compare against the period
						sum = {1'b0, elapsed[i]} + ticks;
						elapsed[i] = sum[ptb_pkg::TMO_W] ? '1 : sum[ptb_pkg::TMO_W-1:0];
						if (elapsed[i] >= period[i]) begin
							elapsed[i] = '0;
							if (i < ptb_pkg::MASK_W)
								st.expired[i] = 1'b1;
						end
					end
				end
			end else if (op == ptb_pkg::OP_ALLOC) begin
				// lowest free channel, zero period refused
				st.rejected = 1'b1;
				if (tmo != '0) begin
					for (int i = 0; i < ptb_pkg::CHANNELS; i++) begin
						if (!in_use[i] && st.rejected) begin
							in_use[i]   = 1'b1;
							running[i]  = 1'b0;
							elapsed[i]  = '0;
							period[i]   = tmo;
							st.granted  = ptb_pkg::CH_W'(i);
							st.timeout  = tmo;
							st.rejected = 1'b0;
						end
					end
				end
			end else if (op <= ptb_pkg::OP_QUERY) begin
				if (!live) begin
					if (op == ptb_pkg::OP_SET_TIMEOUT)
						st.rejected = 1'b1;
				end else begin
					case (op)
						ptb_pkg::OP_FREE: begin
							in_use[ch]  = 1'b0;
							running[ch] = 1'b0;
							elapsed[ch] = '0;
						end
						ptb_pkg::OP_START:   running[ch] = 1'b1;
						ptb_pkg::OP_STOP:    running[ch] = 1'b0;
						ptb_pkg::OP_TOGGLE:  running[ch] = !running[ch];
						ptb_pkg::OP_RESTART: begin
							elapsed[ch] = '0;
							running[ch] = 1'b1;
						end
						ptb_pkg::OP_RESET: begin
							elapsed[ch] = '0;
							running[ch] = 1'b0;
						end
						ptb_pkg::OP_SET_TIMEOUT: begin
							if (tmo != '0) begin
								period[ch]  = tmo;
								elapsed[ch] = '0;
							end else begin
								st.rejected = 1'b1;
							end
						end
						default: ;
					endcase
					if (in_use[ch]) begin
						st.enabled = running[ch];
						st.timeout = period[ch];
					end
				end
			end
			owed_status.push_back(st);
		endfunction

		// Compare one accepted result beat with the oldest owed status
		task check_result(timer_status_t got);
			timer_status_t want;
			beats_seen++;
			if (owed_status.size() == 0) begin
				report($sformatf("result with nothing pending: %h", got));
				return;
			end
			want = owed_status.pop_front();
			if (got.expired !== want.expired)
				report($sformatf("expired_mask %h, want %h", got.expired, want.expired));
			if (got.granted !== want.granted)
				report($sformatf("granted_channel %h, want %h", got.granted, want.granted));
			if (got.rejected !== want.rejected)
				report($sformatf("rejected %b, want %b", got.rejected, want.rejected));
			if (got.enabled !== want.enabled)
				report($sformatf("channel_enabled %b, want %b", got.enabled, want.enabled));
			if (got.timeout !== want.timeout)
				report($sformatf("channel_timeout %h, want %h", got.timeout, want.timeout));
		endtask
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         in_valid;
	logic                         in_stall;
	logic [ptb_pkg::OP_W-1:0]     operation;
	logic [ptb_pkg::CH_W-1:0]     channel;
	logic [ptb_pkg::TICK_W-1:0]   tick_count;
	logic [ptb_pkg::TMO_W-1:0]    timeout_value;
	logic                         out_valid;
	logic                         out_stall;
	logic [ptb_pkg::MASK_W-1:0]   expired_mask;
	logic [ptb_pkg::CH_W-1:0]     granted_channel;
	logic                         rejected;
	logic                         channel_enabled;
	logic [ptb_pkg::TMO_W-1:0]    channel_timeout;

	bit                           idle_on = 1'b1;
	timer_bank_checker            bank_model = new();

	periodic_timer_bank_core uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.operation       (operation),
		.channel         (channel),
		.tick_count      (tick_count),
		.timeout_value   (timeout_value),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.expired_mask    (expired_mask),
		.granted_channel (granted_channel),
		.rejected        (rejected),
		.channel_enabled (channel_enabled),
		.channel_timeout (channel_timeout)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Present one operation beat, with an occasional idle burst ahead of it
	task automatic issue_op(input logic [ptb_pkg::OP_W-1:0] op,
			input logic [ptb_pkg::CH_W-1:0] ch, input logic [ptb_pkg::TICK_W-1:0] ticks,
			input logic [ptb_pkg::TMO_W-1:0] tmo);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		channel       <= ch;
		tick_count    <= ticks;
		timeout_value <= tmo;
		do @(posedge clk); while (in_stall);
	endtask

	// Random operation, weighted toward ticks and keeping channels busy
	task automatic issue_random_op();
		int                           pick;
		logic [ptb_pkg::OP_W-1:0]     op;
		logic [ptb_pkg::CH_W-1:0]     ch;
		logic [ptb_pkg::TICK_W-1:0]   ticks;
		logic [ptb_pkg::TMO_W-1:0]    tmo;
		pick = $urandom_range(0, 99);
		if (pick < 34)      op = ptb_pkg::OP_TICK;
		else if (pick < 46) op = ptb_pkg::OP_ALLOC;
		else if (pick < 51) op = ptb_pkg::OP_FREE;
		else if (pick < 61) op = ptb_pkg::OP_START;
		else if (pick < 65) op = ptb_pkg::OP_STOP;
		else if (pick < 71) op = ptb_pkg::OP_TOGGLE;
		else if (pick < 77) op = ptb_pkg::OP_RESTART;
		else if (pick < 81) op = ptb_pkg::OP_RESET;
		else if (pick < 89) op = ptb_pkg::OP_SET_TIMEOUT;
		else if (pick < 96) op = ptb_pkg::OP_QUERY;
		else                op = ptb_pkg::OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));

		// mostly present channels, now and then any index, the absent one included
		if ($urandom_range(0, 7) == 0)
			ch = ptb_pkg::CH_W'($urandom);
		else
			ch = ptb_pkg::CH_W'($urandom_range(0, ptb_pkg::CHANNELS - 1));

		case ($urandom_range(0, 7))
			0:       ticks = ptb_pkg::TICK_W'($urandom_range(1, 65535));
			1:       ticks = '1;
			2:       ticks = ptb_pkg::TICK_W'($urandom_range(1, 8));
			default: ticks = ptb_pkg::TICK_W'($urandom_range(1, 4000));
		endcase

		case ($urandom_range(0, 9))
			0:       tmo = '0;
			1:       tmo = $urandom;
			2:       tmo = '1;
			3:       tmo = $urandom_range(1, 16);
			default: tmo = $urandom_range(1, 60000);
		endcase

		issue_op(op, ch, ticks, tmo);
	endtask

	// Result side: random stall bursts between quiet stretches
	initial begin : stall_gen
		out_stall = 1'b0;
		forever begin
			repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 25)) @(posedge clk);
			if (idle_on) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watch both channels; a beat moves when valid is high and stall is low
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				bank_model.check_result(timer_status_t'({expired_mask, granted_channel,
					rejected, channel_enabled, channel_timeout}));
			if (in_valid && !in_stall)
				bank_model.note_operation(operation, channel, tick_count, timeout_value);
		end
	end

	initial begin : stimulus
		in_valid      = 1'b0;
		operation     = ptb_pkg::OP_TICK;
		channel       = '0;
		tick_count    = '0;
		timeout_value = '0;
		arst_n        = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty bank, refusals, full bank, expiry, every operation
		issue_op(ptb_pkg::OP_QUERY, 2'd0, 16'd1, 32'd0);
		issue_op(ptb_pkg::OP_SET_TIMEOUT, 2'd1, 16'd1, 32'd5);
		issue_op(ptb_pkg::OP_ALLOC, 2'd0, 16'd1, 32'd0);
		issue_op(ptb_pkg::OP_ALLOC, 2'd0, 16'd1, 32'hFFFF_FFFF);
		issue_op(ptb_pkg::OP_ALLOC, 2'd3, 16'd1, 32'd100);
		issue_op(ptb_pkg::OP_ALLOC, 2'd0, 16'd1, 32'd1);
		issue_op(ptb_pkg::OP_ALLOC, 2'd0, 16'd1, 32'd7);
		issue_op(ptb_pkg::OP_START, 2'd1, 16'd1, 32'd0);
		issue_op(ptb_pkg::OP_START, 2'd2, 16'd1, 32'd0);
		issue_op(ptb_pkg::OP_TICK, 2'd0, 16'd0, 32'd0);
		issue_op(ptb_pkg::OP_TICK, 2'd3, 16'd99, 32'hFFFF_FFFF);
		issue_op(ptb_pkg::OP_TICK, 2'd0, 16'd1, 32'd0);
		issue_op(ptb_pkg::OP_TOGGLE, 2'd0, 16'd1, 32'd0);
		issue_op(ptb_pkg::OP_TICK, 2'd0, 16'hFFFF, 32'd0);
		issue_op(ptb_pkg::OP_SET_TIMEOUT, 2'd1, 16'd1, 32'd0);
		issue_op(ptb_pkg::OP_SET_TIMEOUT, 2'd1, 16'd1, 32'hFFFF_FFFE);
		issue_op(ptb_pkg::OP_STOP, 2'd1, 16'd1, 32'd0);
		issue_op(ptb_pkg::OP_RESTART, 2'd1, 16'd1, 32'd0);
		issue_op(ptb_pkg::OP_RESET, 2'd2, 16'd1, 32'd0);
		issue_op(ptb_pkg::OP_TOGGLE, 2'd2, 16'd1, 32'd0);
		issue_op(ptb_pkg::OP_QUERY, 2'd3, 16'd1, 32'd9);
		issue_op(OP_UNDEF_HI, 2'd3, 16'hFFFF, 32'hFFFF_FFFF);
		issue_op(OP_UNDEF_LO, 2'd1, 16'd1, 32'd3);
		issue_op(ptb_pkg::OP_FREE, 2'd1, 16'd1, 32'd0);
		issue_op(ptb_pkg::OP_ALLOC, 2'd0, 16'd1, 32'd50);

		// Random operations, no idling on either side in the final stretch
		for (int n = 0; n < RANDOM_OPS; n++) begin
			if (n == RANDOM_OPS - CALM_OPS)
				idle_on = 1'b0;
			issue_random_op();
		end
		in_valid <= 1'b0;

		while (bank_model.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (bank_model.mismatches == 0 && bank_model.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Hang guard, far beyond the slowest legal run
	initial begin : watchdog
		#(WATCHDOG_NS);
		$display("Mismatches found");
		$finish;
	end

endmodule
